// ----- hdl/chacha20_keystream_xor_assert.svh -----
// assertion macros shared by the checker of the keystream xor block
// ante and cons are boolean expressions sampled on the rising edge of clk
// the using module provides clk and rst_n
`ifndef CHACHA20_KEYSTREAM_XOR_ASSERT_SVH
`define CHACHA20_KEYSTREAM_XOR_ASSERT_SVH

// same-cycle implication
`define CCX_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CCX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ccx_pkg.sv -----
// ---------------------------------------------------------------------------
// ccx_pkg
// Types, constants and round functions of the ChaCha20 keystream xor block.
// ---------------------------------------------------------------------------
`default_nettype none

package ccx_pkg;

    // block constant "expand 32-byte k"
    localparam logic [31:0] SIGMA0 = 32'h61707865;
    localparam logic [31:0] SIGMA1 = 32'h3320646e;
    localparam logic [31:0] SIGMA2 = 32'h79622d32;
    localparam logic [31:0] SIGMA3 = 32'h6b206574;

    localparam int DOUBLE_ROUNDS_DEF = 10;
    localparam int BLOCK_BYTES       = 64;
    localparam int POS_W             = $clog2(BLOCK_BYTES);
    localparam int QUEUE_DEPTH       = 4;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY0      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY1      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY2      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY3      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONCE     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_CTR = 3'd5;

    typedef logic [15:0][31:0] words_t;
    typedef logic [3:0][31:0]  quad_t;

    typedef struct packed {
        logic [7:0] data_in;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
    } out_item_t;

    typedef struct packed {
        logic [63:0] key0;
        logic [63:0] key1;
        logic [63:0] key2;
        logic [63:0] key3;
        logic [63:0] nonce;
        logic [31:0] start_ctr;
    } cfg_t;

    // one classified byte between front and back
    typedef struct packed {
        logic [31:0]      ctr;
        logic [POS_W-1:0] pos;
        logic [7:0]       data;
        logic             last;
    } q_entry_t;

    // status of the block generator
    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] tag;
    } core_stat_t;

    // input block of the cipher for one counter value
    function automatic words_t block_init(input cfg_t cfg, input logic [31:0] ctr);
        words_t w;
        w[0]  = SIGMA0;
        w[1]  = SIGMA1;
        w[2]  = SIGMA2;
        w[3]  = SIGMA3;
        w[4]  = cfg.key0[31:0];
        w[5]  = cfg.key0[63:32];
        w[6]  = cfg.key1[31:0];
        w[7]  = cfg.key1[63:32];
        w[8]  = cfg.key2[31:0];
        w[9]  = cfg.key2[63:32];
        w[10] = cfg.key3[31:0];
        w[11] = cfg.key3[63:32];
        w[12] = ctr;
        w[13] = cfg.nonce[31:0];
        w[14] = cfg.nonce[63:32];
        w[15] = 32'h0;
        return w;
    endfunction

    // quarter round on (a, b, c, d)
    function automatic quad_t quarter(input quad_t v);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        quad_t       r;
        a = v[0];
        b = v[1];
        c = v[2];
        d = v[3];
        a = a + b; d = d ^ a; d = {d[15:0], d[31:16]};
        c = c + d; b = b ^ c; b = {b[19:0], b[31:20]};
        a = a + b; d = d ^ a; d = {d[23:0], d[31:24]};
        c = c + d; b = b ^ c; b = {b[24:0], b[31:25]};
        r[0] = a;
        r[1] = b;
        r[2] = c;
        r[3] = d;
        return r;
    endfunction

    // one round: column round when diag is low, diagonal round otherwise
    function automatic words_t round_step(input words_t s, input logic diag);
        words_t w;
        quad_t  q;
        int     ib;
        int     ic;
        int     id;
        w = s;
        for (int i = 0; i < 4; i++)
        begin
            ib = diag ? (4 + ((i + 1) & 3))  : (4 + i);
            ic = diag ? (8 + ((i + 2) & 3))  : (8 + i);
            id = diag ? (12 + ((i + 3) & 3)) : (12 + i);
            q = quarter({s[id], s[ic], s[ib], s[i]});
            w[i]  = q[0];
            w[ib] = q[1];
            w[ic] = q[2];
            w[id] = q[3];
        end
        return w;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/ccx_front.sv -----
// ---------------------------------------------------------------------------
// ccx_front
// Accepts input items and tags each byte with its block counter and position.
// ---------------------------------------------------------------------------
`default_nettype none

module ccx_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire ccx_pkg::in_item_t  in_item,
    input  wire logic [31:0]        start_ctr,
    input  wire logic               q_full,
    output logic                    push,
    output ccx_pkg::q_entry_t       push_entry
);

    logic [31:0]               ctr_reg;
    logic [31:0]               ctr_next;
    logic [ccx_pkg::POS_W-1:0] pos_reg;
    logic [ccx_pkg::POS_W-1:0] pos_next;
    logic [31:0]               base_ctr;
    logic [ccx_pkg::POS_W-1:0] base_pos;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // a first byte restarts counter and position
    always_comb
    begin
        base_ctr = in_item.first_byte ? start_ctr : ctr_reg;
        base_pos = in_item.first_byte ? '0 : pos_reg;
        pos_next = base_pos + 1'b1;
        ctr_next = (&base_pos) ? base_ctr + 32'd1 : base_ctr;

        push_entry.ctr  = base_ctr;
        push_entry.pos  = base_pos;
        push_entry.data = in_item.data_in;
        push_entry.last = in_item.last_byte;
    end

    // stream position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctr_reg <= '0;
            pos_reg <= '0;
        end
        else if (push)
        begin
            ctr_reg <= ctr_next;
            pos_reg <= pos_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ccx_queue.sv -----
// ---------------------------------------------------------------------------
// ccx_queue
// Short first-in first-out queue of tagged bytes between front and back.
// ---------------------------------------------------------------------------
`default_nettype none

module ccx_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ccx_pkg::q_entry_t push_entry,
    output logic                   full,
    input  wire logic              pop,
    output logic                   head_valid,
    output ccx_pkg::q_entry_t      head
);

    localparam int DEPTH = ccx_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    ccx_pkg::q_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

// ----- hdl/ccx_core.sv -----
// ---------------------------------------------------------------------------
// ccx_core
// Iterative ChaCha block generator, one round per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module ccx_core #(
    parameter int DOUBLE_ROUNDS = ccx_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic [31:0]     start_ctr,
    input  wire ccx_pkg::cfg_t   cfg,
    output ccx_pkg::core_stat_t  stat,
    output ccx_pkg::words_t      result
);

    localparam int ROUNDS  = 2 * DOUBLE_ROUNDS;
    localparam int ROUND_W = $clog2(ROUNDS + 1);

    logic                busy_reg;
    logic [ROUND_W-1:0]  cnt_reg;
    logic [31:0]         ctr_reg;
    ccx_pkg::words_t     x_reg;
    ccx_pkg::words_t     init_w;
    logic                last_round;

    assign last_round = (cnt_reg == ROUND_W'(ROUNDS));

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && last_round;
    assign stat.tag  = ctr_reg;

    // feed-forward add of the input block
    always_comb
    begin
        init_w = ccx_pkg::block_init(cfg, ctr_reg);
        for (int i = 0; i < 16; i++)
            result[i] = x_reg[i] + init_w[i];
    end

    // round sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (last_round)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // working state: column round on even steps, diagonal round on odd steps
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= ccx_pkg::block_init(cfg, start_ctr);
            ctr_reg <= start_ctr;
        end
        else if (busy_reg && !last_round)
        begin
            x_reg <= ccx_pkg::round_step(x_reg, cnt_reg[0]);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ccx_back.sv -----
// ---------------------------------------------------------------------------
// ccx_back
// Holds the current and the prefetched keystream block, drives the block
// generator and xors queued bytes into the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module ccx_back #(
    parameter int DOUBLE_ROUNDS = ccx_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  wire ccx_pkg::q_entry_t head,
    output logic                   pop,
    input  wire ccx_pkg::cfg_t     cfg,
    input  wire logic              cfg_write,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output ccx_pkg::out_item_t     out_item
);

    ccx_pkg::words_t     cur_reg;
    logic [31:0]         cur_tag_reg;
    logic                cur_valid_reg;
    ccx_pkg::words_t     pf_reg;
    logic [31:0]         pf_tag_reg;
    logic                pf_valid_reg;
    logic                core_live_reg;
    logic                out_valid_reg;
    ccx_pkg::out_item_t  out_item_reg;

    ccx_pkg::core_stat_t core_stat;
    ccx_pkg::words_t     core_result;
    logic                core_start;
    logic [31:0]         core_ctr;
    logic                core_fill;

    logic                need;
    logic                hit;
    logic                miss;
    logic                take;
    logic [31:0]         ks_word;
    logic [7:0]          ks_byte;

    ccx_core #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (core_start),
        .start_ctr (core_ctr),
        .cfg       (cfg),
        .stat      (core_stat),
        .result    (core_result)
    );

    // byte at position zero opens a new block, taken from the prefetch buffer
    always_comb
    begin
        need = (head.pos == '0);
        hit  = pf_valid_reg && (pf_tag_reg == head.ctr);
        miss = head_valid && need && !hit;
        take = !out_valid_reg || !out_stall;
        pop  = head_valid && take && (!need || hit);

        ks_word = cur_reg[head.pos[ccx_pkg::POS_W-1:2]];
        ks_byte = need ? pf_reg[0][7:0] : ks_word[{head.pos[1:0], 3'b000} +: 8];

        core_start = !core_stat.busy && !cfg_write && (miss || (cur_valid_reg && !pf_valid_reg));
        core_ctr   = miss ? head.ctr : cur_tag_reg + 32'd1;
        core_fill  = core_stat.done && core_live_reg;
    end

    // block buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pf_valid_reg  <= 1'b0;
            core_live_reg <= 1'b0;
        end
        else
        begin
            if (pop && need)
                cur_valid_reg <= 1'b1;

            if (cfg_write)
                pf_valid_reg <= 1'b0;
            else if (core_fill)
                pf_valid_reg <= 1'b1;
            else if (pop && need)
                pf_valid_reg <= 1'b0;

            if (cfg_write)
                core_live_reg <= 1'b0;
            else if (core_start)
                core_live_reg <= 1'b1;
        end
    end

    // block buffer data
    always_ff @(posedge clk)
    begin
        if (pop && need)
        begin
            cur_reg     <= pf_reg;
            cur_tag_reg <= pf_tag_reg;
        end
        if (core_fill)
        begin
            pf_reg     <= core_result;
            pf_tag_reg <= core_stat.tag;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take)
            out_valid_reg <= pop;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_item_reg.data_out <= head.data ^ ks_byte;
            out_item_reg.last_out <= head.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ----- hdl/chacha20_keystream_xor.sv -----
// Path: a byte is registered in the queue and then in the output register while
// a block is ready; a byte that opens a block not yet computed waits until the
// round unit generates it, after any prefetch for another counter it must finish.
// Throughput: 1 byte per cycle while the output is not stalled; the next block
// is prefetched by the one-round-per-cycle generator while the current 64 bytes stream out.
// Reset: asynchronous, active low; clears counter, position, queue and buffers.
// ---------------------------------------------------------------------------
// chacha20_keystream_xor
// Byte stream xor with a ChaCha20 keystream, configurable key, nonce and
// start counter.
// ---------------------------------------------------------------------------
`default_nettype none

module chacha20_keystream_xor #(
    parameter int DOUBLE_ROUNDS = ccx_pkg::DOUBLE_ROUNDS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire ccx_pkg::in_item_t                  in_item,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output ccx_pkg::out_item_t                      out_item,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [ccx_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [63:0]                        cfg_data
);

    ccx_pkg::cfg_t     cfg_reg;
    logic              cfg_write;
    logic              q_push;
    ccx_pkg::q_entry_t q_push_entry;
    logic              q_full;
    logic              q_pop;
    logic              q_head_valid;
    ccx_pkg::q_entry_t q_head;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                ccx_pkg::CFG_KEY0:      cfg_reg.key0      <= cfg_data;
                ccx_pkg::CFG_KEY1:      cfg_reg.key1      <= cfg_data;
                ccx_pkg::CFG_KEY2:      cfg_reg.key2      <= cfg_data;
                ccx_pkg::CFG_KEY3:      cfg_reg.key3      <= cfg_data;
                ccx_pkg::CFG_NONCE:     cfg_reg.nonce     <= cfg_data;
                ccx_pkg::CFG_START_CTR: cfg_reg.start_ctr <= cfg_data[31:0];
                default:                cfg_reg           <= cfg_reg;
            endcase
        end
    end

    ccx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .start_ctr  (cfg_reg.start_ctr),
        .q_full     (q_full),
        .push       (q_push),
        .push_entry (q_push_entry)
    );

    ccx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    ccx_back #(
        .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .cfg        (cfg_reg),
        .cfg_write  (cfg_write),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule

`default_nettype wire

// ----- hdl/ccx_checker.sv -----
// ---------------------------------------------------------------------------
// ccx_checker
// Port-level checks of the keystream xor block: output hold under stall, idle
// ports when empty and bounds on the number of items in flight.
// ---------------------------------------------------------------------------
`default_nettype none

`include "chacha20_keystream_xor_assert.svh"

module ccx_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire ccx_pkg::out_item_t out_item
);

    localparam int MAX_FLIGHT = ccx_pkg::QUEUE_DEPTH + 1;
    localparam int FLIGHT_W   = $clog2(MAX_FLIGHT + 1) + 1;

    logic [FLIGHT_W-1:0] flight_reg;
    logic [FLIGHT_W-1:0] flight_next;
    logic                in_acc;
    logic                out_acc;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // items accepted but not yet delivered
    always_comb
    begin
        flight_next = flight_reg;
        if (in_acc && !out_acc)
            flight_next = flight_reg + 1'b1;
        else if (out_acc && !in_acc)
            flight_next = flight_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flight_reg <= '0;
        else
            flight_reg <= flight_next;
    end

    `CCX_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "stalled output item changed")
    `CCX_ASSERT_NOW(a_flight_bound, 1'b1, flight_reg <= FLIGHT_W'(MAX_FLIGHT), "too many items in flight")
    `CCX_ASSERT_NOW(a_empty_idle, flight_reg == '0, !in_stall && !out_valid, "empty block stalls or shows an item")
    `CCX_ASSERT_NOW(a_no_underflow, out_valid, flight_reg != '0, "output item without an accepted input item")

endmodule

bind chacha20_keystream_xor ccx_checker u_ccx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

`default_nettype wire
